// ===== src/nearest_wall_ray_cast_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the nearest wall ray cast unit
// Clocked assertions that can be removed as a group with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef NEAREST_WALL_RAY_CAST_UNIT_MACROS_SVH
`define NEAREST_WALL_RAY_CAST_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define NWRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nwrc assertion failed");
`define NWRC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("nwrc forbidden condition");
`else
`define NWRC_ASSERT(lbl, clk, rst_n, prop)
`define NWRC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== src/nwrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest wall ray cast package
// Shared types and constants of the ray cast unit and its channels.
// ----------------------------------------------------------------------------
package nwrc_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 17;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int NUM_W   = 52;
    localparam int DEN_W   = 34;
    localparam int PROD_W  = 51;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUB,
        ST_TEST,
        ST_DIV,
        ST_PICK,
        ST_NEXT,
        ST_XMUL,
        ST_XDIV,
        ST_YMUL,
        ST_YDIV,
        ST_DONE
    } state_t;

endpackage

// ===== src/nwrc_if.sv =====
// ----------------------------------------------------------------------------
// Nearest wall ray cast channels
// Input and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface nwrc_in_if;
    import nwrc_pkg::*;

    logic                valid;
    logic                ready;
    logic                op;
    logic [SLOT_W-1:0]   wall_slot;
    coord_t              wall_start_x;
    coord_t              wall_start_y;
    coord_t              wall_end_x;
    coord_t              wall_end_y;
    coord_t              origin_x;
    coord_t              origin_y;
    coord_t              dir_x;
    coord_t              dir_y;

    modport source (
        output valid, op, wall_slot, wall_start_x, wall_start_y, wall_end_x, wall_end_y,
        output origin_x, origin_y, dir_x, dir_y,
        input  ready
    );

    modport sink (
        input  valid, op, wall_slot, wall_start_x, wall_start_y, wall_end_x, wall_end_y,
        input  origin_x, origin_y, dir_x, dir_y,
        output ready
    );
endinterface

interface nwrc_out_if;
    import nwrc_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    coord_t              hit_x;
    coord_t              hit_y;
    logic [DIST_W-1:0]   hit_distance;

    modport source (output valid, hit, hit_x, hit_y, hit_distance, input ready);
    modport sink   (input valid, hit, hit_x, hit_y, hit_distance, output ready);
endinterface

// ===== src/nearest_wall_ray_cast_unit.sv =====
// ----------------------------------------------------------------------------
// Nearest wall ray cast unit
// Finds the nearest wall segment hit by a ray, walls held in a wall memory.
// ----------------------------------------------------------------------------
// A beat on in_ch with op LOAD writes one wall into the wall memory and
// gives no result. A beat with op CAST tests walls 0 to wall_count-1
// (limited to MAX_WALLS) and gives one beat on out_ch.
// Per wall the unit reads the memory, forms the cross products, tests the
// hit and steps to the next wall. A hit first runs the serial divider, which
// makes one quotient bit per cycle, and then keeps the nearest hit. When some
// wall was hit, the hit point is formed for x and then for y in the serial
// multiplier and the same divider.
// The result beat appears in the same cycle as the unit returns to idle and
// can take the next item.
// The unit takes one item at a time. A finished result waits in the output
// register while the next item is accepted; a later cast stalls in its final
// state until the receiver has taken the waiting beat.
// Reset clears the control state and wall_count. The wall memory is not
// cleared: walls must be loaded before a cast reads them.
// ----------------------------------------------------------------------------
`include "nearest_wall_ray_cast_unit_macros.svh"

module nearest_wall_ray_cast_unit #(
    parameter int MAX_WALLS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    nwrc_in_if.sink                   in_ch,
    nwrc_out_if.source                out_ch,
    input  logic                      cfg_wr_en,
    input  logic [nwrc_pkg::COUNT_W-1:0] cfg_wr_data
);
    import nwrc_pkg::*;

    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CW = $clog2(MAX_WALLS + 1);

    function automatic coord_t fix_coord(
        input coord_t            base,
        input logic              neg,
        input logic [NUM_W-1:0]  quo,
        input logic              rem_nz
    );
        logic signed [NUM_W+1:0] q_s;
        logic signed [NUM_W+1:0] sum;
        q_s = $signed({2'b00, quo});
        if (neg)
        begin
            q_s = -(q_s + $signed({{(NUM_W+1){1'b0}}, rem_nz}));
        end
        sum = q_s + $signed({{(NUM_W+2-COORD_W){base[COORD_W-1]}}, base});
        if (sum > 54'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (sum < -54'sd32768)
        begin
            return 16'sh8000;
        end
        return sum[COORD_W-1:0];
    endfunction

    logic [63:0] wall_mem [MAX_WALLS];
    logic [63:0] rdata_reg;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]      wall_count_reg;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           n_reg, n_next;
    coord_t                  px_reg, px_next, py_reg, py_next;
    coord_t                  dx_reg, dx_next, dy_reg, dy_next;
    logic signed [32:0]      p_dxey_reg, p_dxey_next, p_dyex_reg, p_dyex_next;
    logic signed [33:0]      p_wxey_reg, p_wxey_next, p_wyex_reg, p_wyex_next;
    logic signed [32:0]      p_wxdy_reg, p_wxdy_next, p_wydx_reg, p_wydx_next;
    logic signed [33:0]      c_reg, c_next;
    logic signed [34:0]      nt_reg, nt_next;
    logic signed [33:0]      ns_reg, ns_next;
    logic [DEN_W-1:0]        cpos_reg, cpos_next;
    logic [DEN_W-1:0]        ntpos_reg, ntpos_next;
    logic                    found_reg, found_next;
    logic [NUM_W-1:0]        best_t4_reg, best_t4_next;
    logic [DEN_W-1:0]        best_nt_reg, best_nt_next;
    logic [DEN_W-1:0]        best_c_reg, best_c_next;
    logic [DEN_W-1:0]        div_rem_reg, div_rem_next;
    logic [NUM_W-1:0]        div_quo_reg, div_quo_next;
    logic [5:0]              step_reg, step_next;
    logic [PROD_W-1:0]       acc_reg, acc_next, mcand_reg, mcand_next;
    logic [COORD_W-1:0]      mplier_reg, mplier_next;
    coord_t                  hx_reg, hx_next, hy_reg, hy_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_hit_reg, out_hit_next;
    coord_t                  out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [DIST_W-1:0]       out_dist_reg, out_dist_next;

    logic                    in_acc;
    logic                    wall_we;
    logic [AW+5:0]           slot_wide;
    logic [CW+6:0]           count_wide;
    logic [CW-1:0]           n_cast;
    logic signed [16:0]      ex, ey, wx, wy;
    logic                    c_neg;
    logic signed [33:0]      c_abs;
    logic signed [34:0]      nt_n;
    logic signed [33:0]      ns_n;
    logic                    wall_hit;
    logic [DEN_W-1:0]        div_den;
    logic [DEN_W:0]          rem_sh;
    logic                    div_ge;
    logic [DEN_W-1:0]        rem_new;
    logic [NUM_W-1:0]        quo_new;
    logic [PROD_W-1:0]       acc_sum;
    logic                    out_free;

    // FSM outputs
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        in_acc      = in_ch.valid && in_ch.ready;
        slot_wide   = {{AW{1'b0}}, in_ch.wall_slot};
        wall_we     = in_acc && (in_ch.op == OP_LOAD) && (slot_wide < MAX_WALLS);
        out_free    = !out_valid_reg || out_ch.ready;
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[slot_wide[AW-1:0]] <= {in_ch.wall_start_x, in_ch.wall_start_y,
                                            in_ch.wall_end_x, in_ch.wall_end_y};
        end
        rdata_reg <= wall_mem[idx_reg[AW-1:0]];
    end

    always_comb
    begin
        count_wide = {{CW{1'b0}}, wall_count_reg};
        n_cast     = (count_wide > MAX_WALLS) ? CW'(MAX_WALLS) : count_wide[CW-1:0];

        ex = $signed({rdata_reg[31], rdata_reg[31:16]})
           - $signed({rdata_reg[63], rdata_reg[63:48]});
        ey = $signed({rdata_reg[15], rdata_reg[15:0]})
           - $signed({rdata_reg[47], rdata_reg[47:32]});
        wx = $signed({rdata_reg[63], rdata_reg[63:48]}) - $signed({px_reg[15], px_reg});
        wy = $signed({rdata_reg[47], rdata_reg[47:32]}) - $signed({py_reg[15], py_reg});

        c_neg = c_reg[33];
        c_abs = c_neg ? -c_reg : c_reg;
        nt_n  = c_neg ? -nt_reg : nt_reg;
        ns_n  = c_neg ? -ns_reg : ns_reg;
        wall_hit = (c_reg != '0) && !nt_n[34] && !ns_n[33] && (ns_n <= c_abs);

        div_den = (state_reg == ST_DIV) ? cpos_reg : best_c_reg;
        rem_sh  = {div_rem_reg, div_quo_reg[NUM_W-1]};
        div_ge  = rem_sh >= {1'b0, div_den};
        rem_new = div_ge ? DEN_W'(rem_sh - {1'b0, div_den}) : rem_sh[DEN_W-1:0];
        quo_new = {div_quo_reg[NUM_W-2:0], div_ge};

        acc_sum = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_ch.op == OP_CAST))
                begin
                    state_next = (n_cast == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_TEST;
            ST_TEST: state_next = wall_hit ? ST_DIV : ST_NEXT;
            ST_DIV:  state_next = (step_reg == 6'(NUM_W - 1)) ? ST_PICK : ST_DIV;
            ST_PICK: state_next = ST_NEXT;
            ST_NEXT:
            begin
                if (idx_reg + 1'b1 == n_reg)
                begin
                    state_next = found_reg ? ST_XMUL : ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_XMUL: state_next = (step_reg == 6'(COORD_W - 1)) ? ST_XDIV : ST_XMUL;
            ST_XDIV: state_next = (step_reg == 6'(NUM_W - 1)) ? ST_YMUL : ST_XDIV;
            ST_YMUL: state_next = (step_reg == 6'(COORD_W - 1)) ? ST_YDIV : ST_YMUL;
            ST_YDIV: state_next = (step_reg == 6'(NUM_W - 1)) ? ST_DONE : ST_YDIV;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        idx_next = idx_reg;       n_next = n_reg;
        px_next = px_reg;         py_next = py_reg;
        dx_next = dx_reg;         dy_next = dy_reg;
        p_dxey_next = p_dxey_reg; p_dyex_next = p_dyex_reg;
        p_wxey_next = p_wxey_reg; p_wyex_next = p_wyex_reg;
        p_wxdy_next = p_wxdy_reg; p_wydx_next = p_wydx_reg;
        c_next = c_reg;           nt_next = nt_reg;       ns_next = ns_reg;
        cpos_next = cpos_reg;     ntpos_next = ntpos_reg;
        found_next = found_reg;   best_t4_next = best_t4_reg;
        best_nt_next = best_nt_reg; best_c_next = best_c_reg;
        div_rem_next = div_rem_reg; div_quo_next = div_quo_reg;
        step_next = step_reg;
        acc_next = acc_reg;       mcand_next = mcand_reg; mplier_next = mplier_reg;
        hx_next = hx_reg;         hy_next = hy_reg;
        out_hit_next = out_hit_reg; out_x_next = out_x_reg; out_y_next = out_y_reg;
        out_dist_next = out_dist_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        case (state_reg)
            ST_IDLE:
            begin
                px_next = in_ch.origin_x;
                py_next = in_ch.origin_y;
                dx_next = in_ch.dir_x;
                dy_next = in_ch.dir_y;
                idx_next = '0;
                n_next = n_cast;
                found_next = 1'b0;
            end
            ST_MUL:
            begin
                p_dxey_next = dx_reg * ey;
                p_dyex_next = dy_reg * ex;
                p_wxey_next = wx * ey;
                p_wyex_next = wy * ex;
                p_wxdy_next = wx * dy_reg;
                p_wydx_next = wy * dx_reg;
            end
            ST_SUB:
            begin
                c_next  = 34'(p_dxey_reg) - 34'(p_dyex_reg);
                nt_next = 35'(p_wxey_reg) - 35'(p_wyex_reg);
                ns_next = 34'(p_wxdy_reg) - 34'(p_wydx_reg);
            end
            ST_TEST:
            begin
                cpos_next    = c_abs;
                ntpos_next   = nt_n[DEN_W-1:0];
                div_rem_next = '0;
                div_quo_next = {4'b0000, nt_n[DEN_W-1:0], 14'b0};
                step_next    = '0;
            end
            ST_DIV, ST_XDIV, ST_YDIV:
            begin
                div_rem_next = rem_new;
                div_quo_next = quo_new;
                step_next    = step_reg + 1'b1;
                if (step_reg == 6'(NUM_W - 1))
                begin
                    acc_next    = '0;
                    mcand_next  = {{(PROD_W-DEN_W){1'b0}}, best_nt_reg};
                    mplier_next = dy_reg[15] ? 16'(-dy_reg) : dy_reg;
                    step_next   = '0;
                    if (state_reg == ST_XDIV)
                    begin
                        hx_next = fix_coord(px_reg, dx_reg[15], quo_new, rem_new != '0);
                    end
                    if (state_reg == ST_YDIV)
                    begin
                        hy_next = fix_coord(py_reg, dy_reg[15], quo_new, rem_new != '0);
                    end
                end
            end
            ST_PICK:
            begin
                if (!found_reg || (div_quo_reg < best_t4_reg))
                begin
                    found_next   = 1'b1;
                    best_t4_next = div_quo_reg;
                    best_nt_next = ntpos_reg;
                    best_c_next  = cpos_reg;
                end
            end
            ST_NEXT:
            begin
                idx_next    = idx_reg + 1'b1;
                acc_next    = '0;
                mcand_next  = {{(PROD_W-DEN_W){1'b0}}, best_nt_reg};
                mplier_next = dx_reg[15] ? 16'(-dx_reg) : dx_reg;
                step_next   = '0;
            end
            ST_XMUL, ST_YMUL:
            begin
                acc_next    = acc_sum;
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[COORD_W-1:1]};
                step_next   = step_reg + 1'b1;
                if (step_reg == 6'(COORD_W - 1))
                begin
                    div_rem_next = '0;
                    div_quo_next = {1'b0, acc_sum};
                    step_next    = '0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = found_reg;
                    out_x_next     = found_reg ? hx_reg : '0;
                    out_y_next     = found_reg ? hy_reg : '0;
                    if (!found_reg)
                    begin
                        out_dist_next = '0;
                    end
                    else if (best_t4_reg > NUM_W'(DIST_MAX))
                    begin
                        out_dist_next = DIST_MAX;
                    end
                    else
                    begin
                        out_dist_next = best_t4_reg[DIST_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wall_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            idx_reg        <= '0;
            n_reg          <= '0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            step_reg      <= step_next;
            if (cfg_wr_en)
            begin
                wall_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;  py_reg <= py_next;
        dx_reg <= dx_next;  dy_reg <= dy_next;
        p_dxey_reg <= p_dxey_next;  p_dyex_reg <= p_dyex_next;
        p_wxey_reg <= p_wxey_next;  p_wyex_reg <= p_wyex_next;
        p_wxdy_reg <= p_wxdy_next;  p_wydx_reg <= p_wydx_next;
        c_reg <= c_next;  nt_reg <= nt_next;  ns_reg <= ns_next;
        cpos_reg <= cpos_next;  ntpos_reg <= ntpos_next;
        best_t4_reg <= best_t4_next;
        best_nt_reg <= best_nt_next;
        best_c_reg  <= best_c_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        acc_reg <= acc_next;  mcand_reg <= mcand_next;  mplier_reg <= mplier_next;
        hx_reg <= hx_next;  hy_reg <= hy_next;
        out_hit_reg <= out_hit_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_dist_reg <= out_dist_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.hit          = out_hit_reg;
    assign out_ch.hit_x        = out_x_reg;
    assign out_ch.hit_y        = out_y_reg;
    assign out_ch.hit_distance = out_dist_reg;

    `NWRC_ASSERT(a_out_from_done, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    `NWRC_ASSERT(a_read_in_range, clk, rst_n,
        (state_reg == ST_READ) |-> (idx_reg < n_reg))
    `NWRC_ASSERT_NEVER(a_miss_is_zero, clk, rst_n,
        out_valid_reg && !out_hit_reg
        && (out_x_reg != '0 || out_y_reg != '0 || out_dist_reg != '0))

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest wall ray cast unit testbench
// Loads wall segments and casts rays through the unit under several wall
// counts. Each cast is predicted here with exact integer math, and every
// beat on the result channel is checked field by field against the oldest
// prediction. The sender runs in random bursts and the receiver stalls on a
// pattern of its own.
// ----------------------------------------------------------------------------
module tb;
    import nwrc_pkg::*;

    localparam int NUM_SLOTS = 64;
    localparam int DRAIN_CYCLES = 4000;

    typedef struct {
        logic              op;
        logic [SLOT_W-1:0] slot;
        coord_t            sx, sy, ex, ey;
        coord_t            ox, oy, dx, dy;
    } ray_item_t;

    typedef struct {
        logic              hit;
        coord_t            hx, hy;
        logic [DIST_W-1:0] distance;
    } hit_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;

    nwrc_in_if  in_ch ();
    nwrc_out_if out_ch ();

    nearest_wall_ray_cast_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ray_item_t   pending_items[$];
    hit_result_t expected_hits[$];
    coord_t      wall_ax[NUM_SLOTS], wall_ay[NUM_SLOTS];
    coord_t      wall_bx[NUM_SLOTS], wall_by[NUM_SLOTS];
    bit          wall_loaded[NUM_SLOTS];
    int          walls_tested;
    int          errors = 0;
    int          results_seen = 0;

    always #10 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.op = OP_LOAD;
        in_ch.wall_slot = '0;
        in_ch.wall_start_x = '0;
        in_ch.wall_start_y = '0;
        in_ch.wall_end_x = '0;
        in_ch.wall_end_y = '0;
        in_ch.origin_x = '0;
        in_ch.origin_y = '0;
        in_ch.dir_x = '0;
        in_ch.dir_y = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return coord_t'(v);
    endfunction

    function automatic hit_result_t cast_nearest(ray_item_t it);
        hit_result_t r;
        longint px, py, dx, dy, ex, ey, wx, wy, c, nt, ns, t4, best_t4;
        bit found;
        px = it.ox;
        py = it.oy;
        dx = it.dx;
        dy = it.dy;
        found = 0;
        best_t4 = 0;
        r = '{hit: 1'b0, hx: '0, hy: '0, distance: '0};
        for (int i = 0; i < walls_tested; i++)
        begin
            ex = longint'(wall_bx[i]) - longint'(wall_ax[i]);
            ey = longint'(wall_by[i]) - longint'(wall_ay[i]);
            wx = longint'(wall_ax[i]) - px;
            wy = longint'(wall_ay[i]) - py;
            c = dx * ey - dy * ex;
            nt = wx * ey - wy * ex;
            ns = wx * dy - wy * dx;
            if (c == 0)
                continue;
            if (c < 0)
            begin
                c = -c;
                nt = -nt;
                ns = -ns;
            end
            if (nt < 0 || ns < 0 || ns > c)
                continue;
            t4 = (nt * 16384) / c;
            if (!found || t4 < best_t4)
            begin
                found = 1;
                best_t4 = t4;
                r.hit = 1'b1;
                r.hx = clamp_coord(px + floor_div(dx * nt, c));
                r.hy = clamp_coord(py + floor_div(dy * nt, c));
                r.distance = (best_t4 > 131071) ? DIST_MAX : best_t4[DIST_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic add_item(ray_item_t it);
        if (it.op == OP_LOAD)
        begin
            wall_ax[it.slot] = it.sx;
            wall_ay[it.slot] = it.sy;
            wall_bx[it.slot] = it.ex;
            wall_by[it.slot] = it.ey;
            wall_loaded[it.slot] = 1'b1;
        end
        else
        begin
            expected_hits = {expected_hits, cast_nearest(it)};
        end
        pending_items = {pending_items, it};
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom_range(0, 65535));
    endfunction

    function automatic coord_t near_coord(int center, int spread);
        return coord_t'(center + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic ray_item_t make_load(int slot, bit wide);
        ray_item_t it;
        int cx, cy;
        it = '{default: '0};
        it.op = OP_LOAD;
        it.slot = slot[SLOT_W-1:0];
        if (wide)
        begin
            it.sx = rand_coord();
            it.sy = rand_coord();
            it.ex = rand_coord();
            it.ey = rand_coord();
        end
        else
        begin
            cx = $signed($urandom_range(0, 4000)) - 2000;
            cy = $signed($urandom_range(0, 4000)) - 2000;
            it.sx = near_coord(cx, 800);
            it.sy = near_coord(cy, 800);
            it.ex = near_coord(cx, 800);
            it.ey = near_coord(cy, 800);
        end
        it.ox = rand_coord();
        it.oy = rand_coord();
        it.dx = rand_coord();
        it.dy = rand_coord();
        return it;
    endfunction

    function automatic ray_item_t make_cast(bit wide);
        ray_item_t it;
        int dx;
        real dyr;
        it = '{default: '0};
        it.op = OP_CAST;
        it.slot = SLOT_W'($urandom_range(0, 63));
        it.sx = rand_coord();
        it.sy = rand_coord();
        it.ex = rand_coord();
        it.ey = rand_coord();
        if (wide)
        begin
            it.ox = rand_coord();
            it.oy = rand_coord();
            it.dx = coord_t'($signed($urandom_range(0, 32768)) - 16384);
            it.dy = coord_t'($signed($urandom_range(0, 32768)) - 16384);
        end
        else
        begin
            it.ox = near_coord(0, 2500);
            it.oy = near_coord(0, 2500);
            dx = $signed($urandom_range(0, 32768)) - 16384;
            dyr = $sqrt(268435456.0 - real'(dx) * real'(dx));
            it.dx = coord_t'(dx);
            it.dy = coord_t'($rtoi(dyr));
            if ($urandom_range(0, 1))
                it.dy = -it.dy;
        end
        return it;
    endfunction

    function automatic ray_item_t cast_at(int ox, int oy, int dx, int dy);
        ray_item_t it;
        it = make_cast(1'b0);
        it.ox = coord_t'(ox);
        it.oy = coord_t'(oy);
        it.dx = coord_t'(dx);
        it.dy = coord_t'(dy);
        return it;
    endfunction

    function automatic ray_item_t wall_at(int slot, int ax, int ay, int bx, int by);
        ray_item_t it;
        it = make_load(slot, 1'b0);
        it.sx = coord_t'(ax);
        it.sy = coord_t'(ay);
        it.ex = coord_t'(bx);
        it.ey = coord_t'(by);
        return it;
    endfunction

    task automatic drain();
        while (pending_items.size() != 0 || in_ch.valid || expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_wall_count(int n);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n[COUNT_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        walls_tested = (n > NUM_SLOTS) ? NUM_SLOTS : n;
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                add_item(make_load($urandom_range(0, 63), $urandom_range(0, 4) == 0));
            else
                add_item(make_cast($urandom_range(0, 4) == 0));
        end
    endtask

    initial
    begin
        int phase_count[9];
        int phase_items[9];
        phase_count = '{0, 1, 64, 2, 5, 127, 3, 16, 9};
        phase_items = '{150, 250, 40, 250, 250, 30, 250, 200, 330};
        walls_tested = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            wall_loaded[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_item(cast_at(0, 0, 16384, 0));
        add_item(wall_at(0, 160, -160, 160, 160));
        add_item(wall_at(1, 160, 160, 160, -160));
        add_item(wall_at(2, 320, 0, 640, 0));
        add_item(wall_at(3, 100, 100, 100, 100));
        add_item(wall_at(63, -32768, 32767, 32767, -32768));
        drain();
        set_wall_count(4);
        add_item(cast_at(0, 0, 16384, 0));
        add_item(cast_at(0, 0, -16384, 0));
        add_item(cast_at(0, 0, 0, 0));
        add_item(cast_at(0, 160, 16384, 0));
        add_item(cast_at(0, -160, 16384, 0));
        add_item(cast_at(-32768, 0, 16384, 0));
        add_item(cast_at(-32768, 0, 1, 0));
        add_item(cast_at(32767, -32768, -16384, 16384));
        add_item(cast_at(160, 0, 0, -16384));
        add_item(cast_at(0, 0, 11585, 11585));
        add_item(cast_at(-32768, -32768, 16384, 16384));
        drain();

        for (int p = 0; p < 9; p++)
        begin
            set_wall_count(phase_count[p]);
            run_random(phase_items[p]);
            if (p == 0)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (!wall_loaded[i])
                        add_item(make_load(i, 1'b0));
            end
            drain();
        end

        if (errors == 0)
            $display("nearest_wall_ray_cast_unit regression: pass");
        else
            $display("nearest_wall_ray_cast_unit regression: fail");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("nearest_wall_ray_cast_unit regression: fail");
        $finish;
    end

    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!(in_ch.valid && !in_ch.ready) && rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                void'(pending_items.pop_front());
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.op <= pending_items[0].op;
                in_ch.wall_slot <= pending_items[0].slot;
                in_ch.wall_start_x <= pending_items[0].sx;
                in_ch.wall_start_y <= pending_items[0].sy;
                in_ch.wall_end_x <= pending_items[0].ex;
                in_ch.wall_end_y <= pending_items[0].ey;
                in_ch.origin_x <= pending_items[0].ox;
                in_ch.origin_y <= pending_items[0].oy;
                in_ch.dir_x <= pending_items[0].dx;
                in_ch.dir_y <= pending_items[0].dy;
                if (burst_left <= 0)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    int ready_cycle = 0;
    int hold_left = 0;
    bit held_once = 1'b0;

    always @(posedge clk)
    begin
        ready_cycle <= ready_cycle + 1;
        if (!held_once && results_seen >= 300)
        begin
            held_once <= 1'b1;
            hold_left <= 600;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            case ((ready_cycle / 700) % 3)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= (ready_cycle % 5) != 0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        hit_result_t want;
        bit bad;
        bad = 1'b0;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result beat, hit %0b x %0d y %0d distance %0d",
                         $time, out_ch.hit, out_ch.hit_x, out_ch.hit_y, out_ch.hit_distance);
                bad = 1'b1;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (out_ch.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_ch.hit);
                    bad = 1'b1;
                end
                if (out_ch.hit_x !== want.hx)
                begin
                    $display("%0t: hit_x expected %0d actual %0d", $time, want.hx, out_ch.hit_x);
                    bad = 1'b1;
                end
                if (out_ch.hit_y !== want.hy)
                begin
                    $display("%0t: hit_y expected %0d actual %0d", $time, want.hy, out_ch.hit_y);
                    bad = 1'b1;
                end
                if (out_ch.hit_distance !== want.distance)
                begin
                    $display("%0t: hit_distance expected %0d actual %0d",
                             $time, want.distance, out_ch.hit_distance);
                    bad = 1'b1;
                end
            end
            if (bad)
                errors <= errors + 1;
        end
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/nwrc_pkg.sv
src/nwrc_if.sv
src/nearest_wall_ray_cast_unit.sv
sim/tb.sv
